// ===== design/key_binding_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the key binding table.
// ----------------------------------------------------------------------------
`ifndef KEY_BINDING_TABLE_ASSERT_SVH
`define KEY_BINDING_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kbt_pkg.sv =====
// ----------------------------------------------------------------------------
// kbt_pkg
// Shared types and constants of the key binding table.
// ----------------------------------------------------------------------------
package kbt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  value;
  } entry_t;

  typedef struct packed {
    logic   shift;
    entry_t tail;
  } ring_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             busy;
  } kbt_stat_t;

endpackage

// ===== design/kbt_cell.sv =====
// ----------------------------------------------------------------------------
// kbt_cell
// One slot of the rotating entry ring; takes the entry on its din (its neighbor's, or the ring tail) on a shift.
// ----------------------------------------------------------------------------
module kbt_cell
  import kbt_pkg::*;
(
  input  logic   clk,
  input  logic   shift,
  input  entry_t din,
  output entry_t dout
);

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry_r <= din;
    end
  end

  assign dout = entry_r;

endmodule

// ===== design/kbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbt_ctrl
// Sequencer that rotates the ring past the head cell and edits entries there.
// ----------------------------------------------------------------------------
module kbt_ctrl
  import kbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_key,
  input  logic [7:0]  in_func_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_was_present,
  output logic [7:0]  out_bound_index,
  input  entry_t      head,
  output ring_ctl_t   ring,
  output kbt_stat_t   stat
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FILL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             found_r, found_nxt;
  logic             append_r, append_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [7:0]       val_r, val_nxt;
  entry_t           last_r, last_nxt;
  logic [1:0]       op_r;
  logic [15:0]      key_r;
  logic [7:0]       fidx_r;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             present_r, present_nxt;
  logic [7:0]       bound_r, bound_nxt;

  logic [CNT_W-1:0] idx_ext;
  logic             in_use;
  logic             hit;
  logic             at_end;
  logic             take_out;
  logic [1:0]       res_status;
  logic             res_present;
  logic [7:0]       res_bound;

  assign idx_ext  = {1'b0, idx_r};
  assign in_use   = idx_ext < cnt_r;
  assign hit      = in_use && (head.key == key_r) && (key_r != 16'd0) && !found_r;
  assign at_end   = idx_r == LAST_IDX;
  assign take_out = !out_valid_r || out_ready;

  always_comb begin
    res_status  = ST_NOT_FOUND;
    res_present = 1'b0;
    res_bound   = 8'd0;
    case (op_r)
      OP_SET: begin
        if (key_r == 16'd0) begin
          res_status = ST_NOT_FOUND;
        end else if (found_r) begin
          res_status  = ST_OK;
          res_present = 1'b1;
          res_bound   = fidx_r;
        end else if (append_r) begin
          res_status = ST_OK;
          res_bound  = fidx_r;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (found_r) begin
          res_status  = ST_OK;
          res_present = 1'b1;
        end
      end
      default: begin
        if (found_r) begin
          res_status  = ST_OK;
          res_present = 1'b1;
          res_bound   = val_r;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    append_nxt    = append_r;
    slot_nxt      = slot_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    present_nxt   = present_r;
    bound_nxt     = bound_r;
    ring.shift    = 1'b0;
    ring.tail     = head;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_SCAN;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          append_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        ring.shift = 1'b1;
        if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = idx_r;
          val_nxt   = head.value;
          if (op_r == OP_SET) begin
            ring.tail.value = fidx_r;
          end
        end
        if ((op_r == OP_SET) && (idx_ext == cnt_r) && !found_r && (key_r != 16'd0)) begin
          ring.tail.key   = key_r;
          ring.tail.value = fidx_r;
          append_nxt      = 1'b1;
        end
        if (idx_ext == cnt_r - CNT_W'(1)) begin
          last_nxt = head;
        end
        if (at_end) begin
          idx_nxt = '0;
          if ((op_r == OP_DELETE) && (found_r || hit)) begin
            state_nxt = S_FILL;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_FILL: begin
        ring.shift = 1'b1;
        if (idx_r == slot_r) begin
          ring.tail = last_r;
        end
        if (at_end) begin
          idx_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (take_out) begin
          out_valid_nxt = 1'b1;
          status_nxt    = res_status;
          present_nxt   = res_present;
          bound_nxt     = res_bound;
          state_nxt     = S_IDLE;
          if (append_r) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else if ((op_r == OP_DELETE) && found_r) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r   <= found_nxt;
    append_r  <= append_nxt;
    slot_r    <= slot_nxt;
    val_r     <= val_nxt;
    last_r    <= last_nxt;
    status_r  <= status_nxt;
    present_r <= present_nxt;
    bound_r   <= bound_nxt;
    if ((state_r == S_IDLE) && in_valid) begin
      op_r   <= in_op;
      key_r  <= in_key;
      fidx_r <= in_func_index;
    end
  end

  assign in_ready        = state_r == S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_was_present = present_r;
  assign out_bound_index = bound_r;
  assign stat.count      = cnt_r;
  assign stat.busy       = state_r != S_IDLE;

endmodule

// ===== design/key_binding_table.sv =====
// Each request rotates the entry ring once past its single head cell; a delete that hits
// rotates it a second time to move the last entry into the freed slot. The result is
// registered only once the output side can take it, and no new request is accepted
// until then.
// Reset: rst_n, synchronous, active low; clears the entry count and handshake state.
// The ring contents are not cleared; slots at or above the count are never read.
// ----------------------------------------------------------------------------
// key_binding_table
// Associative table of key codes to function indices held in a ring of cells.
// ----------------------------------------------------------------------------
`include "key_binding_table_assert.svh"

module key_binding_table
  import kbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_key,
  input  logic [7:0]  in_func_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_was_present,
  output logic [7:0]  out_bound_index
);

  entry_t    ring_q [TABLE_DEPTH];
  ring_ctl_t ring;
  kbt_stat_t stat;

  kbt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_func_index   (in_func_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_was_present (out_was_present),
    .out_bound_index (out_bound_index),
    .head            (ring_q[0]),
    .ring            (ring),
    .stat            (stat)
  );

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    if (k == TABLE_DEPTH - 1) begin : g_tail
      kbt_cell u_cell (
        .clk   (clk),
        .shift (ring.shift),
        .din   (ring.tail),
        .dout  (ring_q[k])
      );
    end else begin : g_body
      kbt_cell u_cell (
        .clk   (clk),
        .shift (ring.shift),
        .din   (ring_q[k+1]),
        .dout  (ring_q[k])
      );
    end
  end

  `KBT_ASSERT_NOW(a_count_bound, 1'b1, stat.count <= CNT_W'(TABLE_DEPTH),
    "entry count exceeds table depth")
  `KBT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready && stat.busy,
    "block accepted an item but did not start work")
  `KBT_ASSERT_NOW(a_full_means_full, out_valid && (out_status == ST_FULL),
    stat.count == CNT_W'(TABLE_DEPTH), "table full reported while slots are free")
  `KBT_ASSERT_NOW(a_ready_idle, in_ready, !stat.busy,
    "ready raised while a scan is in progress")

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Key binding table testbench
// Drives lookup, set, delete and unused-op requests into the table, predicts each result
// from a behavioral copy of the table, and compares every result field.
// ----------------------------------------------------------------------------
module testbench
  import kbt_pkg::*;
();

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int SETTLE_CYCLES = 4 * TABLE_DEPTH + 64;
  localparam int LONG_HOLD_CYCLES = 4000;

  typedef struct {
    logic [1:0] status;
    logic       was_present;
    logic [7:0] bound_index;
  } binding_result_t;

  typedef enum {RX_OPEN, RX_LIGHT_STALL, RX_HEAVY_STALL} rx_mode_t;

  class binding_scoreboard;
    logic [15:0]     bound_keys[TABLE_DEPTH];
    logic [7:0]      bound_funcs[TABLE_DEPTH];
    int              bound_count;
    binding_result_t expected_q[$];
    int              errors;
    int              checked;
    int              full_refusals;
    int              peak_count;
    int              ops_seen[4];

    // Applies one accepted request to the table copy and queues its result.
    function void note_request(logic [1:0] op, logic [15:0] key, logic [7:0] func_index);
      int              slot;
      bit              hit;
      binding_result_t res;
      res = '{ST_NOT_FOUND, 1'b0, 8'd0};
      slot = bound_count;
      if (key != 16'd0) begin
        for (int i = 0; i < bound_count; i++) begin
          if (bound_keys[i] == key) begin
            slot = i;
            break;
          end
        end
      end
      hit = (key != 16'd0) && (slot < bound_count);
      ops_seen[op]++;
      case (op)
        OP_SET: begin
          if (hit) begin
            bound_funcs[slot] = func_index;
            res = '{ST_OK, 1'b1, func_index};
          end else if (key != 16'd0 && bound_count < TABLE_DEPTH) begin
            bound_keys[bound_count] = key;
            bound_funcs[bound_count] = func_index;
            bound_count++;
            res = '{ST_OK, 1'b0, func_index};
          end else if (key != 16'd0) begin
            res.status = ST_FULL;
            full_refusals++;
          end
        end
        OP_DELETE: begin
          if (hit) begin
            bound_keys[slot] = bound_keys[bound_count-1];
            bound_funcs[slot] = bound_funcs[bound_count-1];
            bound_count--;
            res = '{ST_OK, 1'b1, 8'd0};
          end
        end
        default: begin
          if (hit) begin
            res = '{ST_OK, 1'b1, bound_funcs[slot]};
          end
        end
      endcase
      if (bound_count > peak_count) begin
        peak_count = bound_count;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic was_present, logic [7:0] bound_index);
      binding_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      if (status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, status);
        errors++;
      end
      if (was_present !== exp_res.was_present) begin
        $error("was_present: expected %0d, got %0d", exp_res.was_present, was_present);
        errors++;
      end
      if (bound_index !== exp_res.bound_index) begin
        $error("bound_index: expected %0d, got %0d", exp_res.bound_index, bound_index);
        errors++;
      end
    endfunction

    function logic [15:0] pick_present();
      if (bound_count == 0) begin
        return 16'($urandom_range(1, 65535));
      end
      return bound_keys[$urandom_range(0, bound_count - 1)];
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = OP_LOOKUP;
  logic [15:0] in_key = 16'd0;
  logic [7:0]  in_func_index = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_was_present;
  logic [7:0]  out_bound_index;

  logic        long_hold_go = 1'b0;
  logic        hold_taken;
  int          hold_cnt;
  rx_mode_t    rx_mode;
  int          rx_left;
  int          burst_left = 0;
  logic [15:0] key_pool[24];

  binding_scoreboard table_model = new();

  key_binding_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_key         (in_key),
    .in_func_index  (in_func_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_was_present(out_was_present),
    .out_bound_index(out_bound_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        table_model.note_request(in_op, in_key, in_func_index);
      end
      if (out_valid && out_ready) begin
        table_model.check_result(out_status, out_was_present, out_bound_index);
      end
    end
  end

  // The result side switches between open, lightly stalled and heavily stalled
  // stretches, and takes one long hold-off when the request side asks for it.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_taken <= 1'b0;
      hold_cnt <= 0;
      rx_mode <= RX_OPEN;
      rx_left <= 0;
    end else if (long_hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
        rx_left <= $urandom_range(32, 800);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:        out_ready <= 1'b1;
        RX_LIGHT_STALL: out_ready <= ($urandom_range(0, 3) != 0);
        default:        out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [15:0] random_key();
    return 16'($urandom_range(1, 65535));
  endfunction

  // Offers one item and returns at the edge where it is accepted. Items go
  // out in bursts separated by random gaps.
  task automatic offer(input logic [1:0] op, input logic [15:0] key,
                       input logic [7:0] func_index);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 700) : $urandom_range(0, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= key;
    in_func_index <= func_index;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (table_model.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int          roll;
    logic [15:0] k;
    logic [1:0]  op;

    foreach (key_pool[i]) key_pool[i] = random_key();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, the reserved key, both key extremes, updates and deletes
    // that pull the last entry into the middle of the table.
    offer(OP_LOOKUP, 16'h0001, 8'h00);
    offer(OP_DELETE, 16'hFFFF, 8'hFF);
    offer(OP_SET, 16'h0000, 8'h5A);
    offer(OP_LOOKUP, 16'h0000, 8'h00);
    offer(OP_DELETE, 16'h0000, 8'h00);
    offer(OP_SET, 16'hFFFF, 8'hFF);
    offer(OP_SET, 16'h0001, 8'h00);
    offer(OP_SET, 16'h8000, 8'h80);
    offer(OP_LOOKUP, 16'hFFFF, 8'h00);
    offer(OP_UNUSED, 16'h0001, 8'hFF);
    offer(OP_SET, 16'hFFFF, 8'h01);
    offer(OP_LOOKUP, 16'hFFFF, 8'h00);
    offer(OP_DELETE, 16'h0001, 8'h00);
    offer(OP_LOOKUP, 16'h8000, 8'h00);
    offer(OP_DELETE, 16'h8000, 8'h00);
    offer(OP_DELETE, 16'hFFFF, 8'h00);
    offer(OP_LOOKUP, 16'hFFFF, 8'h00);
    offer(OP_SET, 16'h5555, 8'h55);
    offer(OP_SET, 16'hAAAA, 8'hAA);
    offer(OP_DELETE, 16'h5555, 8'h00);
    offer(OP_LOOKUP, 16'hAAAA, 8'h00);
    offer(OP_DELETE, 16'hAAAA, 8'h00);
    offer(OP_UNUSED, 16'h0000, 8'h00);

    // Mixed traffic on a small set of keys, so most requests hit.
    repeat (180) begin
      roll = $urandom_range(0, 99);
      if (roll < 90) begin
        k = key_pool[$urandom_range(0, 23)];
      end else if (roll < 98) begin
        k = random_key();
      end else begin
        k = 16'h0000;
      end
      roll = $urandom_range(0, 99);
      op = (roll < 40) ? OP_SET : (roll < 70) ? OP_LOOKUP : (roll < 95) ? OP_DELETE : OP_UNUSED;
      offer(op, k, 8'($urandom_range(0, 255)));
    end

    wait_all_results();

    // Results are held back while a burst keeps coming, so the input backs up.
    long_hold_go <= 1'b1;
    burst_left = 12;

    while (table_model.bound_count < TABLE_DEPTH) begin
      if ($urandom_range(0, 9) != 0) begin
        offer(OP_SET, random_key(), 8'($urandom_range(0, 255)));
      end else begin
        offer(OP_LOOKUP, table_model.pick_present(), 8'($urandom_range(0, 255)));
      end
    end

    // Around the full boundary: refused inserts, updates, and delete/insert pairs.
    repeat (60) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        offer(OP_SET, random_key(), 8'($urandom_range(0, 255)));
      end else if (roll < 60) begin
        offer(OP_SET, table_model.pick_present(), 8'($urandom_range(0, 255)));
      end else if (roll < 80) begin
        offer(OP_LOOKUP, table_model.pick_present(), 8'($urandom_range(0, 255)));
      end else if (roll < 90) begin
        offer(OP_DELETE, table_model.pick_present(), 8'($urandom_range(0, 255)));
      end else begin
        offer(OP_LOOKUP, random_key(), 8'($urandom_range(0, 255)));
      end
    end

    while (table_model.bound_count > 4) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        offer(OP_DELETE, table_model.pick_present(), 8'($urandom_range(0, 255)));
      end else if (roll < 90) begin
        offer(OP_LOOKUP, random_key(), 8'($urandom_range(0, 255)));
      end else begin
        offer(OP_SET, random_key(), 8'($urandom_range(0, 255)));
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (table_model.expected_q.size() != 0) begin
      $error("results outstanding at end of run: expected %0d, got %0d",
             0, table_model.expected_q.size());
      table_model.errors++;
    end

    $display("Covered %0d lookups, %0d sets, %0d deletes and %0d unused-op requests;",
             table_model.ops_seen[OP_LOOKUP], table_model.ops_seen[OP_SET],
             table_model.ops_seen[OP_DELETE], table_model.ops_seen[OP_UNUSED]);
    $display("%0d results checked; the table peaked at %0d of %0d entries and refused %0d inserts.",
             table_model.checked, table_model.peak_count, TABLE_DEPTH,
             table_model.full_refusals);
    if (table_model.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
